// ----- sv/bucketed_hash_table_macros.svh -----
// assertion macros for the bucketed hash table
// used by the top level only, no other dependencies
`ifndef BUCKETED_HASH_TABLE_MACROS_SVH
`define BUCKETED_HASH_TABLE_MACROS_SVH
`ifndef SYNTH
`define BHT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BHT_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/bht_pkg.sv -----
// shared types and constants of the bucketed hash table
// no dependencies
`default_nettype none
package bht_pkg;
   localparam int HASH_BITS      = 32;
   localparam int DATA_BITS      = 32;
   localparam int COUNT_BITS     = 7;
   localparam int CSR_DATA_BITS  = 7;
   localparam int CSR_INDEX_BITS = 1;
   localparam int DIGIT_BITS     = 4;
   localparam int DIV_STEPS      = HASH_BITS / DIGIT_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
   localparam int BUCKET_OUT_BITS = 6;
   localparam int NODE_OUT_BITS  = 9;
   localparam int STAT_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_BUCKET_COUNT = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PROBE_ENABLE = 1'b1;
   localparam logic [COUNT_BITS-1:0] BUCKET_COUNT_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } bht_cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_NO_ROOM   = 2'd2,
      STS_DUPLICATE = 2'd3
   } bht_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOK,
      ST_CMP,
      ST_DONE
   } bht_state_type;
endpackage
`default_nettype wire

// ----- sv/bht_divider.sv -----
// remainder unit: hash modulo bucket count, four dividend bits per cycle
// depends on bht_pkg
`default_nettype none
module bht_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bht_pkg::HASH_BITS-1:0]    dividend,
   input  logic [bht_pkg::COUNT_BITS-1:0]   divisor,
   output logic                             done,
   output logic [bht_pkg::COUNT_BITS-1:0]   remainder
);
   import bht_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [HASH_BITS-1:0]    sh_ff, sh_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   div_ff, div_in;

   always_comb begin
      logic [COUNT_BITS-1:0] t;
      logic [COUNT_BITS:0]   w;
      t = rem_ff;
      for (int d = 0; d < DIGIT_BITS; d++) begin
         w = {t, sh_ff[HASH_BITS-1-d]};
         if (w >= {1'b0, div_ff}) begin
            w = w - {1'b0, div_ff};
         end
         t = w[COUNT_BITS-1:0];
      end
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = t;
         sh_in  = sh_ff << DIGIT_BITS;
         cnt_in = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

// ----- sv/bht_store.sv -----
// bucket memory: one row of keys and values per bucket, registered read
// depends on bht_pkg
`default_nettype none
module bht_store #(
   parameter int DEPTH    = 64,
   parameter int ROW_BITS = 256,
   parameter int AW       = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic [ROW_BITS-1:0] wr_data,
   output logic [ROW_BITS-1:0] rd_data
);
   import bht_pkg::*;

   logic [ROW_BITS-1:0] mem [DEPTH];
   logic [ROW_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;
endmodule
`default_nettype wire

// ----- sv/bucketed_hash_table.sv -----
// top level of the bucketed hash table with linear probing
// depends on bht_pkg, bht_divider, bht_store and bucketed_hash_table_macros.svh
//
//   port group   direction  handshake
//   req_*        in         req_valid / req_ready
//   rsp_*        out        rsp_valid / rsp_ready
//   csr_*        in         csr_write, no wait
//
// add/get/remove: accept, then the modulo (4 hash bits per cycle), then a memory
// read and a compare per bucket searched, then the response register;
// an add that probes past full buckets visits each full bucket without a read
// clear skips the modulo and the search; valid masks are flops, reset clears them
// a new request is taken while the response waits, one request in flight
`default_nettype none
`include "bucketed_hash_table_macros.svh"
module bucketed_hash_table #(
   parameter int NUM_BUCKETS  = 64,
   parameter int BUCKET_SLOTS = 4,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [bht_pkg::DATA_BITS-1:0]         req_key,
   input  logic [bht_pkg::HASH_BITS-1:0]         req_key_hash,
   input  logic [bht_pkg::DATA_BITS-1:0]         req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [bht_pkg::DATA_BITS-1:0]         rsp_value_out,
   output logic [bht_pkg::BUCKET_OUT_BITS-1:0]   rsp_bucket_used,
   output logic [bht_pkg::NODE_OUT_BITS-1:0]     rsp_node_count,
   output logic [bht_pkg::STAT_BITS-1:0]         rsp_collision_total,
   output logic [bht_pkg::STAT_BITS-1:0]         rsp_add_fail_total,
   input  logic                                  csr_write,
   input  logic [bht_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bht_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import bht_pkg::*;

   localparam int BIW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int SW       = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int TOTAL    = NUM_BUCKETS * BUCKET_SLOTS;
   localparam int NW       = $clog2(TOTAL + 1);
   localparam int ROW_BITS = BUCKET_SLOTS * (KEY_BITS + VALUE_BITS);
   localparam int CW       = (BIW > COUNT_BITS) ? BIW + 1 : COUNT_BITS + 1;

   bht_state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] bcount_ff, bcount_in;
   logic                  probe_ff, probe_in;
   bht_cmd_type           cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [BIW-1:0]        b_ff, b_in;
   logic [COUNT_BITS-1:0] n_ff, n_in;
   logic [NW-1:0]         entry_ff, entry_in;
   logic [STAT_BITS-1:0]  coll_ff, coll_in;
   logic [STAT_BITS-1:0]  fail_ff, fail_in;
   bht_status_type        status_ff, status_in;
   logic [DATA_BITS-1:0]  vout_ff, vout_in;
   logic [BIW-1:0]        bused_ff, bused_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bht_status_type        rsp_status_ff, rsp_status_in;
   logic [DATA_BITS-1:0]  rsp_vout_ff, rsp_vout_in;
   logic [BUCKET_OUT_BITS-1:0] rsp_bused_ff, rsp_bused_in;
   logic [NODE_OUT_BITS-1:0]   rsp_nodes_ff, rsp_nodes_in;
   logic [STAT_BITS-1:0]  rsp_coll_ff, rsp_coll_in;
   logic [STAT_BITS-1:0]  rsp_fail_ff, rsp_fail_in;
   logic [BUCKET_SLOTS-1:0] mask_ff [NUM_BUCKETS];

   logic                    accept;
   logic [COUNT_BITS-1:0]   nb;
   logic                    div_done;
   logic [COUNT_BITS-1:0]   div_rem;
   logic [BUCKET_SLOTS-1:0] cur_mask;
   logic                    full;
   logic                    more;
   logic [BIW-1:0]          nxt_b;
   logic [BUCKET_SLOTS-1:0] match;
   logic                    hit;
   logic [SW-1:0]           hit_idx;
   logic [SW-1:0]           free_idx;
   logic [ROW_BITS-1:0]     rd_row;
   logic [ROW_BITS-1:0]     wr_row;
   logic [BUCKET_SLOTS-1:0][KEY_BITS-1:0]   rd_keys, wr_keys;
   logic [BUCKET_SLOTS-1:0][VALUE_BITS-1:0] rd_vals, wr_vals;
   logic                    rd_en, wr_en;
   logic                    mask_we, mask_clr;
   logic [BUCKET_SLOTS-1:0] mask_wdata;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      if (bcount_ff == '0) begin
         nb = COUNT_BITS'(1);
      end else if (32'(bcount_ff) > NUM_BUCKETS) begin
         nb = COUNT_BITS'(NUM_BUCKETS);
      end else begin
         nb = bcount_ff;
      end
   end

   bht_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && (bht_cmd_type'(req_command) != CMD_CLEAR)),
      .dividend  (req_key_hash),
      .divisor   (nb),
      .done      (div_done),
      .remainder (div_rem)
   );

   bht_store #(
      .DEPTH    (NUM_BUCKETS),
      .ROW_BITS (ROW_BITS),
      .AW       (BIW)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (b_ff),
      .wr_en   (wr_en),
      .wr_addr (b_ff),
      .wr_data (wr_row),
      .rd_data (rd_row)
   );

   assign {rd_keys, rd_vals} = rd_row;
   assign cur_mask = mask_ff[b_ff];
   assign full     = &cur_mask;
   assign more     = probe_ff && (({1'b0, n_ff} + 8'd1) < {1'b0, nb});
   assign nxt_b    = ((CW'(b_ff) + CW'(1)) == CW'(nb)) ? '0 : b_ff + BIW'(1);

   always_comb begin
      for (int s = 0; s < BUCKET_SLOTS; s++) begin
         match[s] = cur_mask[s] && (rd_keys[s] == key_ff);
      end
      hit      = |match;
      hit_idx  = '0;
      free_idx = '0;
      for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
         if (match[s]) begin
            hit_idx = SW'(s);
         end
         if (!cur_mask[s]) begin
            free_idx = SW'(s);
         end
      end
   end

   always_comb begin
      wr_keys = rd_keys;
      wr_vals = rd_vals;
      wr_keys[free_idx] = key_ff;
      wr_vals[free_idx] = val_ff;
      wr_row = {wr_keys, wr_vals};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (bht_cmd_type'(req_command) == CMD_CLEAR) ? ST_DONE : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (cmd_ff == CMD_ADD && full) begin
               state_in = more ? ST_LOOK : ST_DONE;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (cmd_ff != CMD_ADD && !hit && more) begin
               state_in = ST_LOOK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      bcount_in  = bcount_ff;
      probe_in   = probe_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      b_in       = b_ff;
      n_in       = n_ff;
      entry_in   = entry_ff;
      coll_in    = coll_ff;
      fail_in    = fail_ff;
      status_in  = status_ff;
      vout_in    = vout_ff;
      bused_in   = bused_ff;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      mask_we    = 1'b0;
      mask_clr   = 1'b0;
      mask_wdata = cur_mask;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_vout_in   = rsp_vout_ff;
      rsp_bused_in  = rsp_bused_ff;
      rsp_nodes_in  = rsp_nodes_ff;
      rsp_coll_in   = rsp_coll_ff;
      rsp_fail_in   = rsp_fail_ff;

      if (csr_write) begin
         if (csr_index == REG_BUCKET_COUNT) begin
            bcount_in = csr_wdata;
         end else if (csr_index == REG_PROBE_ENABLE) begin
            probe_in = csr_wdata[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = bht_cmd_type'(req_command);
               key_in    = KEY_BITS'(req_key);
               val_in    = VALUE_BITS'(req_value);
               status_in = STS_OK;
               vout_in   = '0;
               bused_in  = '0;
               if (bht_cmd_type'(req_command) == CMD_CLEAR) begin
                  mask_clr = 1'b1;
                  entry_in = '0;
               end
            end
         end
         ST_DIV: begin
            b_in = BIW'(div_rem);
            n_in = '0;
         end
         ST_LOOK: begin
            if (cmd_ff == CMD_ADD && full) begin
               if (more) begin
                  b_in = nxt_b;
                  n_in = n_ff + COUNT_BITS'(1);
               end else begin
                  fail_in   = fail_ff + STAT_BITS'(1);
                  status_in = STS_NO_ROOM;
               end
            end else begin
               rd_en = 1'b1;
            end
         end
         ST_CMP: begin
            if (cmd_ff == CMD_ADD) begin
               bused_in = b_ff;
               if (hit) begin
                  status_in = STS_DUPLICATE;
               end else begin
                  wr_en   = 1'b1;
                  mask_we = 1'b1;
                  mask_wdata[free_idx] = 1'b1;
                  if (cur_mask != '0) begin
                     coll_in = coll_ff + STAT_BITS'(1);
                  end
                  entry_in = entry_ff + NW'(1);
               end
            end else if (hit) begin
               bused_in = b_ff;
               if (cmd_ff == CMD_GET) begin
                  vout_in = DATA_BITS'(rd_vals[hit_idx]);
               end else begin
                  mask_we = 1'b1;
                  mask_wdata[hit_idx] = 1'b0;
                  if (entry_ff != '0) begin
                     entry_in = entry_ff - NW'(1);
                  end
               end
            end else if (more) begin
               b_in = nxt_b;
               n_in = n_ff + COUNT_BITS'(1);
            end else begin
               status_in = STS_NOT_FOUND;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_vout_in   = vout_ff;
               rsp_bused_in  = BUCKET_OUT_BITS'(bused_ff);
               rsp_nodes_in  = NODE_OUT_BITS'(entry_ff);
               rsp_coll_in   = coll_ff;
               rsp_fail_in   = fail_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bcount_ff    <= BUCKET_COUNT_RESET;
         probe_ff     <= 1'b0;
         entry_ff     <= '0;
         coll_ff      <= '0;
         fail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bcount_ff    <= bcount_in;
         probe_ff     <= probe_in;
         entry_ff     <= entry_in;
         coll_ff      <= coll_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      b_ff          <= b_in;
      n_ff          <= n_in;
      status_ff     <= status_in;
      vout_ff       <= vout_in;
      bused_ff      <= bused_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vout_ff   <= rsp_vout_in;
      rsp_bused_ff  <= rsp_bused_in;
      rsp_nodes_ff  <= rsp_nodes_in;
      rsp_coll_ff   <= rsp_coll_in;
      rsp_fail_ff   <= rsp_fail_in;
   end

   // per-bucket slot occupancy
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BUCKETS; i++) begin
         if (reset || mask_clr) begin
            mask_ff[i] <= '0;
         end else if (mask_we && (b_ff == BIW'(i))) begin
            mask_ff[i] <= mask_wdata;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_value_out       = rsp_vout_ff;
   assign rsp_bucket_used     = rsp_bused_ff;
   assign rsp_node_count      = rsp_nodes_ff;
   assign rsp_collision_total = rsp_coll_ff;
   assign rsp_add_fail_total  = rsp_fail_ff;

   `BHT_ASSERT_NEXT(a_one_in_flight, clock, reset, accept, !req_ready, "request taken while busy")
   `BHT_ASSERT_SAME(a_entry_bound, clock, reset, 1'b1, 32'(entry_ff) <= TOTAL, "entry count overflow")
   `BHT_ASSERT_SAME(a_div_state, clock, reset, div_done, state_ff == ST_DIV, "modulo done out of step")
   `BHT_ASSERT_SAME(a_no_rw_clash, clock, reset, wr_en, !rd_en, "memory read and write together")
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// self-checking testbench of bucketed_hash_table: directed and random requests,
// a behavioral table model predicts every response; depends on bht_pkg and the rtl
`default_nettype none
module tb;
   import bht_pkg::*;

   localparam int NB = 64;
   localparam int NS = 4;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      bht_cmd_type cmd;
      logic [31:0] key;
      logic [31:0] hash;
      logic [31:0] value;
   } request_t;

   typedef struct packed {
      bht_status_type status;
      logic [31:0]    value_out;
      logic [5:0]     bucket;
      logic [8:0]     nodes;
      logic [31:0]    collisions;
      logic [31:0]    add_fails;
   } response_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_command = 0;
   logic [31:0] req_key = 0, req_key_hash = 0, req_value = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [1:0] rsp_status;
   logic [31:0] rsp_value_out;
   logic [5:0] rsp_bucket_used;
   logic [8:0] rsp_node_count;
   logic [31:0] rsp_collision_total, rsp_add_fail_total;
   logic csr_write = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = 0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = 0;

   bucketed_hash_table i_dut (.*);

   // table model
   logic        m_valid [NB*NS];
   logic [31:0] m_key [NB*NS];
   logic [31:0] m_val [NB*NS];
   int          m_fill [NB];
   logic [8:0]  m_nodes;
   logic [31:0] m_coll, m_fail;
   int          m_buckets;
   logic        m_probe;

   request_t  pending_requests[$];
   response_t expected_responses[$];
   logic [31:0] known_keys[$];
   int errors = 0, cycles = 0, accepted = 0, responded = 0;
   int hold_cycles = 0;
   bit hold_done = 0;
   bit in_taken = 0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch on response %0d: %s got %0h want %0h", responded, what, got, want);
   endtask

   function automatic int find_key(int b, logic [31:0] key);
      for (int s = 0; s < NS; s++)
         if (m_valid[b*NS+s] && m_key[b*NS+s] == key) return b*NS + s;
      return -1;
   endfunction

   function automatic response_t table_step(request_t r);
      response_t o;
      int nb, home, b, idx, n;
      bit room;
      nb = m_buckets == 0 ? 1 : (m_buckets > NB ? NB : m_buckets);
      home = r.hash % nb;
      o = '0;
      o.status = STS_OK;
      case (r.cmd)
         CMD_ADD: begin
            b = home;
            room = m_fill[home] < NS;
            if (!room && m_probe)
               for (n = 1; n < nb && !room; n++) begin
                  b = (b + 1 == nb) ? 0 : b + 1;
                  room = m_fill[b] < NS;
               end
            if (!room) begin
               m_fail++;
               o.status = STS_NO_ROOM;
            end else if (find_key(b, r.key) >= 0) begin
               o.status = STS_DUPLICATE;
               o.bucket = 6'(b);
            end else begin
               for (int s = 0; s < NS; s++)
                  if (!m_valid[b*NS+s]) begin
                     m_valid[b*NS+s] = 1;
                     m_key[b*NS+s] = r.key;
                     m_val[b*NS+s] = r.value;
                     break;
                  end
               if (m_fill[b] != 0) m_coll++;
               m_fill[b]++;
               m_nodes++;
               o.bucket = 6'(b);
            end
         end
         CMD_GET, CMD_REMOVE: begin
            b = home;
            idx = -1;
            for (n = 0; n < nb; n++) begin
               idx = find_key(b, r.key);
               if (idx >= 0 || !m_probe) break;
               b = (b + 1 == nb) ? 0 : b + 1;
            end
            if (idx < 0) o.status = STS_NOT_FOUND;
            else begin
               o.bucket = 6'(b);
               if (r.cmd == CMD_GET) o.value_out = m_val[idx];
               else begin
                  m_valid[idx] = 0;
                  if (m_fill[b] != 0) m_fill[b]--;
                  if (m_nodes != 0) m_nodes--;
               end
            end
         end
         default: begin
            for (int i = 0; i < NB*NS; i++) m_valid[i] = 0;
            for (int i = 0; i < NB; i++) m_fill[i] = 0;
            m_nodes = 0;
         end
      endcase
      o.nodes = m_nodes;
      o.collisions = m_coll;
      o.add_fails = m_fail;
      return o;
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   // request handshake seen at the rising edge
   always @(posedge clock) begin
      if (reset) in_taken <= 0;
      else begin
         in_taken <= req_valid && req_ready;
         if (req_valid && req_ready) accepted <= accepted + 1;
      end
   end

   // driver
   int gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || in_taken) begin
            if (gap > 0) begin
               gap <= gap - 1;
               req_valid <= 0;
            end else if (pending_requests.size() > 0) begin
               request_t r;
               r = pending_requests.pop_front();
               req_valid <= 1;
               req_command <= r.cmd;
               req_key <= r.key;
               req_key_hash <= r.hash;
               req_value <= r.value;
               expected_responses.push_back(table_step(r));
               gap <= ($urandom_range(0, 9) < 5) ? 0 :
                      (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) :
                       $urandom_range(1, 3));
            end else req_valid <= 0;
         end
      end
   end

   // receiver with a long hold-off once
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted > 100) begin
            rsp_ready <= 0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles == 300) hold_done <= 1;
         end else
            rsp_ready <= ($urandom_range(0, 9) < 7) ? 1 : ($urandom_range(0, 19) != 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_t w;
         if (expected_responses.size() == 0) begin
            errors++;
            $display("unexpected response");
         end else begin
            w = expected_responses.pop_front();
            if (rsp_status !== w.status) report("status", rsp_status, w.status);
            if (rsp_value_out !== w.value_out) report("value", rsp_value_out, w.value_out);
            if (rsp_bucket_used !== w.bucket) report("bucket", rsp_bucket_used, w.bucket);
            if (rsp_node_count !== w.nodes) report("nodes", rsp_node_count, w.nodes);
            if (rsp_collision_total !== w.collisions)
               report("collisions", rsp_collision_total, w.collisions);
            if (rsp_add_fail_total !== w.add_fails)
               report("add fails", rsp_add_fail_total, w.add_fails);
         end
         responded <= responded + 1;
      end
   end

   task automatic push(bht_cmd_type c, logic [31:0] k, logic [31:0] h, logic [31:0] v);
      request_t r;
      r.cmd = c; r.key = k; r.hash = h; r.value = v;
      pending_requests.push_back(r);
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || expected_responses.size() > 0 || req_valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] d);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_wdata <= d;
      @(negedge clock);
      csr_write <= 0;
      if (idx == REG_BUCKET_COUNT) m_buckets = d;
      else m_probe = d[0];
   endtask

   task automatic random_phase(int count);
      int c;
      logic [31:0] k, h;
      for (int i = 0; i < count; i++) begin
         c = $urandom_range(0, 99);
         if (c < 60 || known_keys.size() == 0) k = $urandom_range(0, 15) == 0 ?
            $urandom() : $urandom_range(0, 40);
         else k = known_keys[$urandom_range(0, known_keys.size() - 1)];
         h = ($urandom_range(0, 3) == 0) ? $urandom() :
             {2'($urandom_range(0, 3)), 30'(k * 7)};
         if (c < 45) begin
            push(CMD_ADD, k, h, $urandom());
            known_keys.push_back(k);
         end else if (c < 75) push(CMD_GET, k, h, $urandom());
         else if (c < 97) push(CMD_REMOVE, k, h, $urandom());
         else push(CMD_CLEAR, $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      for (int i = 0; i < NB*NS; i++) begin
         m_valid[i] = 0; m_key[i] = 0; m_val[i] = 0;
      end
      for (int i = 0; i < NB; i++) m_fill[i] = 0;
      m_nodes = 0; m_coll = 0; m_fail = 0; m_buckets = 64; m_probe = 0;
      repeat (10) @(posedge clock);
      reset <= 0;

      // directed: extremes, duplicate, full bucket, miss, clear
      push(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push(CMD_ADD, 32'h0, 32'h0, 32'h0);
      push(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      push(CMD_ADD, 32'h0, 32'h0, 32'h5);
      for (int i = 1; i <= 4; i++) push(CMD_ADD, i, 32'd64, 32'hA5A5_0000 + i);
      push(CMD_GET, 32'd3, 32'd0, 32'h0);
      push(CMD_REMOVE, 32'd77, 32'd0, 32'h0);
      push(CMD_REMOVE, 32'd2, 32'd0, 32'h0);
      push(CMD_GET, 32'd2, 32'd0, 32'h0);
      push(CMD_CLEAR, 32'h0, 32'h0, 32'h0);
      push(CMD_GET, 32'h0, 32'h0, 32'h0);
      drain();

      // probing, one bucket
      write_csr(REG_PROBE_ENABLE, 7'd1);
      write_csr(REG_BUCKET_COUNT, 7'd1);
      for (int i = 0; i < 6; i++) push(CMD_ADD, 100 + i, $urandom(), i);
      push(CMD_GET, 32'd101, 32'd9, 0);
      random_phase(60);
      drain();

      // probing, a few buckets, then a shrink leaving stranded entries
      write_csr(REG_BUCKET_COUNT, 7'd3);
      random_phase(120);
      drain();
      write_csr(REG_BUCKET_COUNT, 7'd2);
      random_phase(60);
      drain();

      // zero and excess bucket counts, then 64 buckets with probing on
      write_csr(REG_BUCKET_COUNT, 7'd0);
      random_phase(30);
      drain();
      write_csr(REG_BUCKET_COUNT, 7'h7F);
      write_csr(REG_PROBE_ENABLE, 7'd0);
      random_phase(100);
      drain();
      write_csr(REG_BUCKET_COUNT, 7'd64);
      write_csr(REG_PROBE_ENABLE, 7'd1);
      random_phase(130);
      drain();

      $display("covered %0d requests over several bucket counts, probing on and off", accepted);
      $display("responses checked: %0d, mismatches: %0d", responded, errors);
      if (errors == 0 && expected_responses.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
